/* rtl/jss_pkg.sv */
package jss_pkg;

  localparam int MAX_JOBS = 64;
  localparam int MAX_MACHINES = 32;
  localparam int DURATION_BITS = 16;
  localparam int JOB_BITS = $clog2(MAX_JOBS);
  localparam int MACH_BITS = $clog2(MAX_MACHINES);
  localparam int JC_BITS = 7;
  localparam int MC_BITS = 6;
  localparam int SPAN_BITS = 27;
  localparam logic [SPAN_BITS-1:0] SPAN_STALL = '1;
  localparam logic [SPAN_BITS-1:0] SPAN_SAT = {{(SPAN_BITS-1){1'b1}}, 1'b0};
  localparam logic [1:0] CFG_JOB_COUNT = 2'd0;
  localparam logic [1:0] CFG_MACHINE_COUNT = 2'd1;

  typedef struct packed {
    logic init;
    logic idx_rst;
    logic idx_inc;
    logic clr_ns;
    logic cand_clr;
    logic scan_upd;
    logic min_clr;
    logic commit;
    logic advance;
    logic dec;
    logic load_res;
    logic res_stall;
  } cmd_t;

  typedef struct packed {
    logic last_job;
    logic last_mach;
    logic all_done;
    logic any_busy;
  } status_t;

endpackage

/* rtl/job_shop_spt_dispatch_makespan.sv */
// Load items are taken whenever the block is idle and give no result; busy stays low.
// A run item over J jobs and M machines clears the per-job step table, then makes R dispatch
// rounds, each a walk of the per-job table followed by the per-machine passes.
// The makespan is shown with done high for one cycle at the end of the run.
// A synchronous reset returns to idle with both counts at one; routes keep old data.
module job_shop_spt_dispatch_makespan (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              req_type,
  input  logic [jss_pkg::JOB_BITS-1:0]      job_index,
  input  logic [jss_pkg::MACH_BITS-1:0]     step_index,
  input  logic [jss_pkg::MACH_BITS-1:0]     op_machine,
  input  logic [jss_pkg::DURATION_BITS-1:0] op_duration,
  output logic                              done,
  output logic [jss_pkg::SPAN_BITS-1:0]     makespan,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [jss_pkg::JC_BITS-1:0]       cfg_data
);
  import jss_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic    accept;

  assign accept = start && !busy;
  assign cfg_ready = 1'b1;

  jss_ctrl u_ctrl (
    .clk(clk), .rst(rst), .run_req(accept && req_type), .st(st), .cmd(cmd),
    .busy(busy), .done(done)
  );

  jss_dpath u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .load_we(accept && !req_type), .load_job(job_index), .load_step(step_index),
    .load_machine(op_machine), .load_duration(op_duration),
    .cfg_we(cfg_valid && cfg_ready), .cfg_sel(cfg_index), .cfg_value(cfg_data),
    .result(makespan)
  );
endmodule

/* rtl/jss_ctrl.sv */
module jss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             run_req,
  input  jss_pkg::status_t st,
  output jss_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done
);
  import jss_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_SA = 4'd3;
  localparam logic [3:0] S_SB = 4'd4;
  localparam logic [3:0] S_SC = 4'd5;
  localparam logic [3:0] S_CM = 4'd6;
  localparam logic [3:0] S_ADV = 4'd7;
  localparam logic [3:0] S_DC = 4'd8;
  localparam logic [3:0] S_OUT = 4'd9;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (run_req) begin
          cmd.init = 1'b1;
          state_next = S_CLR;
        end
      end
      S_CLR: begin
        cmd.clr_ns = 1'b1;
        if (st.last_job) begin
          cmd.idx_rst = 1'b1;
          state_next = S_CHECK;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_CHECK: begin
        if (st.all_done) begin
          cmd.load_res = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.cand_clr = 1'b1;
          cmd.idx_rst = 1'b1;
          state_next = S_SA;
        end
      end
      S_SA: state_next = S_SB;
      S_SB: state_next = S_SC;
      S_SC: begin
        cmd.scan_upd = 1'b1;
        if (st.last_job) begin
          cmd.idx_rst = 1'b1;
          cmd.min_clr = 1'b1;
          state_next = S_CM;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = S_SA;
        end
      end
      S_CM: begin
        cmd.commit = 1'b1;
        if (st.last_mach) begin
          cmd.idx_rst = 1'b1;
          state_next = S_ADV;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_ADV: begin
        if (!st.any_busy) begin
          cmd.load_res = 1'b1;
          cmd.res_stall = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.advance = 1'b1;
          state_next = S_DC;
        end
      end
      S_DC: begin
        cmd.dec = 1'b1;
        if (st.last_mach) begin
          cmd.idx_rst = 1'b1;
          state_next = S_CHECK;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule

/* rtl/jss_dpath.sv */
module jss_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  jss_pkg::cmd_t                       cmd,
  output jss_pkg::status_t                    st,
  input  logic                                load_we,
  input  logic [jss_pkg::JOB_BITS-1:0]        load_job,
  input  logic [jss_pkg::MACH_BITS-1:0]       load_step,
  input  logic [jss_pkg::MACH_BITS-1:0]       load_machine,
  input  logic [jss_pkg::DURATION_BITS-1:0]   load_duration,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_sel,
  input  logic [jss_pkg::JC_BITS-1:0]         cfg_value,
  output logic [jss_pkg::SPAN_BITS-1:0]       result
);
  import jss_pkg::*;

  localparam int ROUTE_W = MACH_BITS + DURATION_BITS;

  logic [JC_BITS-1:0] job_count;
  logic [MC_BITS-1:0] machine_count;

  logic [ROUTE_W-1:0] route_mem [MAX_JOBS*MAX_MACHINES];
  logic [ROUTE_W-1:0] route_q;
  logic [MC_BITS-1:0] ns_mem [MAX_JOBS];
  logic [MC_BITS-1:0] ns_q;
  logic               skip_q;

  logic [JC_BITS-1:0] idx;
  logic [JC_BITS-1:0] done_cnt;
  logic [SPAN_BITS-1:0] elapsed;
  logic               any;
  logic [DURATION_BITS-1:0] min_step;

  logic [MAX_JOBS-1:0]     job_busy;
  logic [MAX_MACHINES-1:0] m_busy;
  logic [DURATION_BITS-1:0] m_rem [MAX_MACHINES];
  logic [JOB_BITS-1:0]      m_job [MAX_MACHINES];
  logic [MACH_BITS-1:0]     m_step [MAX_MACHINES];
  logic [MAX_MACHINES-1:0]  c_valid;
  logic [DURATION_BITS-1:0] c_dur [MAX_MACHINES];
  logic [JOB_BITS-1:0]      c_job [MAX_MACHINES];
  logic [MACH_BITS-1:0]     c_step [MAX_MACHINES];

  logic [JOB_BITS-1:0]      jidx;
  logic [MACH_BITS-1:0]     midx;
  logic [MACH_BITS-1:0]     r_mach;
  logic [DURATION_BITS-1:0] r_dur;
  logic                     nb;
  logic [DURATION_BITS-1:0] nrem;
  logic [MC_BITS-1:0]       step_inc;
  logic [SPAN_BITS:0]       sum;

  assign jidx = idx[JOB_BITS-1:0];
  assign midx = idx[MACH_BITS-1:0];
  assign r_mach = route_q[ROUTE_W-1:DURATION_BITS];
  assign r_dur = route_q[DURATION_BITS-1:0];
  assign nb = m_busy[midx] | c_valid[midx];
  assign nrem = c_valid[midx] ? c_dur[midx] : m_rem[midx];
  assign step_inc = {1'b0, m_step[midx]} + MC_BITS'(1);
  assign sum = {1'b0, elapsed} + (SPAN_BITS+1)'(min_step);

  assign st.last_job = (idx + JC_BITS'(1)) >= job_count;
  assign st.last_mach = (idx + JC_BITS'(1)) >= JC_BITS'(machine_count);
  assign st.all_done = (done_cnt == job_count) || (machine_count == '0);
  assign st.any_busy = any;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_count <= JC_BITS'(1);
      machine_count <= MC_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_sel)
        CFG_JOB_COUNT: job_count <= (cfg_value > JC_BITS'(MAX_JOBS)) ?
                                    JC_BITS'(MAX_JOBS) : cfg_value;
        CFG_MACHINE_COUNT: machine_count <=
          (cfg_value[MC_BITS-1:0] > MC_BITS'(MAX_MACHINES)) ?
          MC_BITS'(MAX_MACHINES) : cfg_value[MC_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      route_mem[{load_job, load_step}] <= {load_machine, load_duration};
    end
    route_q <= route_mem[{jidx, ns_q[MACH_BITS-1:0]}];
    skip_q <= job_busy[jidx] || (ns_q >= machine_count);
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_ns) begin
      ns_mem[jidx] <= '0;
    end else if (cmd.dec && m_busy[midx] && (m_rem[midx] <= min_step)) begin
      ns_mem[m_job[midx]] <= step_inc;
    end
    ns_q <= ns_mem[jidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      done_cnt <= '0;
      elapsed <= '0;
      any <= 1'b0;
      job_busy <= '0;
      m_busy <= '0;
      c_valid <= '0;
    end else begin
      if (cmd.init) begin
        idx <= '0;
        done_cnt <= '0;
        elapsed <= '0;
        job_busy <= '0;
        m_busy <= '0;
      end
      if (cmd.idx_rst) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + JC_BITS'(1);
      end
      if (cmd.cand_clr) begin
        c_valid <= '0;
      end
      if (cmd.scan_upd && !skip_q && (MC_BITS'(r_mach) < machine_count) &&
          !m_busy[r_mach] && (!c_valid[r_mach] || (r_dur < c_dur[r_mach]))) begin
        c_valid[r_mach] <= 1'b1;
        c_dur[r_mach] <= r_dur;
        c_job[r_mach] <= jidx;
        c_step[r_mach] <= ns_q[MACH_BITS-1:0];
      end
      if (cmd.min_clr) begin
        any <= 1'b0;
      end
      if (cmd.commit) begin
        m_busy[midx] <= nb;
        if (c_valid[midx]) begin
          m_rem[midx] <= c_dur[midx];
          m_job[midx] <= c_job[midx];
          m_step[midx] <= c_step[midx];
          job_busy[c_job[midx]] <= 1'b1;
        end
        if (nb && (!any || (nrem < min_step))) begin
          any <= 1'b1;
          min_step <= nrem;
        end
      end
      if (cmd.advance) begin
        elapsed <= (sum > (SPAN_BITS+1)'(SPAN_SAT)) ? SPAN_SAT : sum[SPAN_BITS-1:0];
      end
      if (cmd.dec && m_busy[midx]) begin
        if (m_rem[midx] <= min_step) begin
          m_rem[midx] <= '0;
          m_busy[midx] <= 1'b0;
          job_busy[m_job[midx]] <= 1'b0;
          if (step_inc == machine_count) begin
            done_cnt <= done_cnt + JC_BITS'(1);
          end
        end else begin
          m_rem[midx] <= m_rem[midx] - min_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_res) begin
      result <= cmd.res_stall ? SPAN_STALL : elapsed;
    end
  end
endmodule

/* rtl/jss_checker.sv */
module jss_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic req_type,
  input logic done
);
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done while idle");
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type) |=> busy)
    else $error("run transfer did not start work");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !req_type) |=> !busy)
    else $error("load transfer made the block busy");
  a_end_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("block not idle after result");
endmodule

bind job_shop_spt_dispatch_makespan jss_checker u_jss_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type), .done(done)
);

/* tb/sv/job_shop_spt_dispatch_makespan_tb.sv */
`timescale 1ns / 100ps

module job_shop_spt_dispatch_makespan_tb;
  import jss_pkg::*;

  localparam int IDLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 900;
  localparam logic [SPAN_BITS-1:0] BIG_SPAN = 27'd4194240;

  typedef enum int {ROW_LOAD, ROW_RUN, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t kind;
    int f0;
    int f1;
    int f2;
    int f3;
    bit known;
    logic [SPAN_BITS-1:0] span;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic req_type = 1'b0;
  logic [JOB_BITS-1:0] job_index = '0;
  logic [MACH_BITS-1:0] step_index = '0;
  logic [MACH_BITS-1:0] op_machine = '0;
  logic [DURATION_BITS-1:0] op_duration = '0;
  logic done;
  logic [SPAN_BITS-1:0] makespan;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [JC_BITS-1:0] cfg_data = '0;

  logic [MACH_BITS-1:0] route_mach_tab [0:MAX_JOBS*MAX_MACHINES-1];
  logic [DURATION_BITS-1:0] route_dur_tab [0:MAX_JOBS*MAX_MACHINES-1];
  bit entry_loaded [0:MAX_JOBS*MAX_MACHINES-1];
  int job_count_sh = 1;
  int mach_count_sh = 1;
  logic [SPAN_BITS-1:0] pending_spans [$];
  stim_row_t stim_tab [$];
  int fail_count = 0;
  int item_count = 0;
  int idle_cycles = 0;
  bit allow_gaps = 1'b1;

  job_shop_spt_dispatch_makespan DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .job_index(job_index), .step_index(step_index), .op_machine(op_machine),
    .op_duration(op_duration), .done(done), .makespan(makespan),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int eff_jobs();
    return job_count_sh > MAX_JOBS ? MAX_JOBS : job_count_sh;
  endfunction

  function automatic int eff_machs();
    return mach_count_sh > MAX_MACHINES ? MAX_MACHINES : mach_count_sh;
  endfunction

  function automatic logic [SPAN_BITS-1:0] predict_makespan();
    int jc;
    int mc;
    int pick;
    int e;
    bit found;
    bit any;
    bit all_done;
    longint best;
    longint stride;
    longint elapsed;
    bit m_busy [0:MAX_MACHINES-1];
    longint m_rem [0:MAX_MACHINES-1];
    bit j_busy [0:MAX_JOBS-1];
    longint j_rem [0:MAX_JOBS-1];
    int j_step [0:MAX_JOBS-1];
    jc = eff_jobs();
    mc = eff_machs();
    elapsed = 0;
    for (int i = 0; i < MAX_MACHINES; i++) begin
      m_busy[i] = 0;
      m_rem[i] = 0;
    end
    for (int i = 0; i < MAX_JOBS; i++) begin
      j_busy[i] = 0;
      j_rem[i] = 0;
      j_step[i] = 0;
    end
    forever begin
      all_done = 1;
      for (int j = 0; j < jc; j++) begin
        if (j_step[j] < mc) all_done = 0;
      end
      if (all_done) break;
      for (int m = 0; m < mc; m++) begin
        found = 0;
        pick = 0;
        best = 0;
        if (!m_busy[m]) begin
          for (int j = 0; j < jc; j++) begin
            if (!j_busy[j] && j_step[j] < mc) begin
              e = j * MAX_MACHINES + j_step[j];
              if (route_mach_tab[e] == m && (!found || route_dur_tab[e] < best)) begin
                found = 1;
                pick = j;
                best = route_dur_tab[e];
              end
            end
          end
          if (found) begin
            m_busy[m] = 1;
            m_rem[m] = best;
            j_busy[pick] = 1;
            j_rem[pick] = best;
          end
        end
      end
      any = 0;
      stride = 0;
      for (int m = 0; m < mc; m++) begin
        if (m_busy[m] && (!any || m_rem[m] < stride)) begin
          any = 1;
          stride = m_rem[m];
        end
      end
      if (!any) return SPAN_STALL;
      elapsed += stride;
      for (int m = 0; m < mc; m++) begin
        if (m_busy[m]) begin
          if (m_rem[m] <= stride) begin
            m_rem[m] = 0;
            m_busy[m] = 0;
          end else begin
            m_rem[m] -= stride;
          end
        end
      end
      for (int j = 0; j < jc; j++) begin
        if (j_busy[j]) begin
          if (j_rem[j] <= stride) begin
            j_rem[j] = 0;
            j_busy[j] = 0;
            j_step[j]++;
          end else begin
            j_rem[j] -= stride;
          end
        end
      end
    end
    return elapsed > longint'(SPAN_SAT) ? SPAN_SAT : SPAN_BITS'(elapsed);
  endfunction

  task automatic send_item(bit rt, int j, int s, int m, int d, bit known,
                           logic [SPAN_BITS-1:0] span);
    int e;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= rt;
    job_index <= JOB_BITS'(j);
    step_index <= MACH_BITS'(s);
    op_machine <= MACH_BITS'(m);
    op_duration <= DURATION_BITS'(d);
    do @(posedge clk); while (busy);
    item_count++;
    if (!rt) begin
      e = j * MAX_MACHINES + s;
      route_mach_tab[e] = MACH_BITS'(m);
      route_dur_tab[e] = DURATION_BITS'(d);
      entry_loaded[e] = 1'b1;
    end else begin
      pending_spans.push_back(known ? span : predict_makespan());
    end
  endtask

  task automatic fill_routes();
    int mc;
    mc = eff_machs();
    for (int j = 0; j < eff_jobs(); j++) begin
      for (int s = 0; s < mc; s++) begin
        if (!entry_loaded[j * MAX_MACHINES + s]) begin
          send_item(1'b0, j, s, $urandom_range(0, mc - 1), $urandom_range(0, 20), 1'b0, '0);
        end
      end
    end
  endtask

  task automatic run_schedule(bit known, logic [SPAN_BITS-1:0] span);
    fill_routes();
    send_item(1'b1, $urandom_range(0, 63), $urandom_range(0, 31), $urandom_range(0, 31),
              $urandom_range(0, 65535), known, span);
  endtask

  task automatic write_reg(int idx, int value);
    start <= 1'b0;
    @(posedge clk);
    while (pending_spans.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= 2'(idx);
    cfg_data <= JC_BITS'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_JOB_COUNT) job_count_sh = value & 8'h7f;
    else if (idx == CFG_MACHINE_COUNT) mach_count_sh = value & 8'h3f;
  endtask

  function automatic stim_row_t row(row_kind_t kind, int f0, int f1, int f2, int f3,
                                    bit known, logic [SPAN_BITS-1:0] span);
    stim_row_t r;
    r.kind = kind;
    r.f0 = f0;
    r.f1 = f1;
    r.f2 = f2;
    r.f3 = f3;
    r.known = known;
    r.span = span;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
      if (done) begin
        if (pending_spans.size() == 0) begin
          $error("makespan: expected none, actual %0d", makespan);
          fail_count++;
        end else begin
          if (makespan !== pending_spans[0]) begin
            $error("makespan: expected %0d, actual %0d", pending_spans[0], makespan);
            fail_count++;
          end
          void'(pending_spans.pop_front());
        end
      end
    end
  end

  initial begin
    int jc;
    int mc;
    int mc_eff;
    int jc_eff;
    int n;
    for (int i = 0; i < MAX_JOBS * MAX_MACHINES; i++) entry_loaded[i] = 1'b0;

    stim_tab.push_back(row(ROW_LOAD, 0, 0, 0, 0, 0, '0));
    stim_tab.push_back(row(ROW_RUN, 0, 0, 0, 0, 1, '0));
    stim_tab.push_back(row(ROW_LOAD, 0, 0, 0, 65535, 0, '0));
    stim_tab.push_back(row(ROW_RUN, 0, 0, 0, 0, 1, 27'd65535));
    stim_tab.push_back(row(ROW_LOAD, 0, 0, 31, 65535, 0, '0));
    stim_tab.push_back(row(ROW_RUN, 0, 0, 0, 0, 1, SPAN_STALL));
    stim_tab.push_back(row(ROW_LOAD, 63, 31, 31, 65535, 0, '0));
    stim_tab.push_back(row(ROW_CFG, CFG_JOB_COUNT, 0, 0, 0, 0, '0));
    stim_tab.push_back(row(ROW_RUN, 0, 0, 0, 0, 1, '0));
    stim_tab.push_back(row(ROW_CFG, CFG_JOB_COUNT, 1, 0, 0, 0, '0));
    stim_tab.push_back(row(ROW_CFG, CFG_MACHINE_COUNT, 0, 0, 0, 0, '0));
    stim_tab.push_back(row(ROW_RUN, 0, 0, 0, 0, 1, '0));
    stim_tab.push_back(row(ROW_CFG, 2, 5, 0, 0, 0, '0));
    stim_tab.push_back(row(ROW_CFG, 3, 127, 0, 0, 0, '0));
    stim_tab.push_back(row(ROW_CFG, CFG_MACHINE_COUNT, 1, 0, 0, 0, '0));
    stim_tab.push_back(row(ROW_CFG, CFG_JOB_COUNT, 2, 0, 0, 0, '0));
    stim_tab.push_back(row(ROW_LOAD, 0, 0, 0, 5, 0, '0));
    stim_tab.push_back(row(ROW_LOAD, 1, 0, 0, 5, 0, '0));
    stim_tab.push_back(row(ROW_RUN, 0, 0, 0, 0, 1, 27'd10));
    stim_tab.push_back(row(ROW_CFG, CFG_MACHINE_COUNT, 63, 0, 0, 0, '0));
    stim_tab.push_back(row(ROW_CFG, CFG_JOB_COUNT, 1, 0, 0, 0, '0));
    stim_tab.push_back(row(ROW_RUN, 0, 0, 0, 0, 0, '0));
    stim_tab.push_back(row(ROW_CFG, CFG_JOB_COUNT, 127, 0, 0, 0, '0));
    stim_tab.push_back(row(ROW_CFG, CFG_MACHINE_COUNT, 1, 0, 0, 0, '0));
    stim_tab.push_back(row(ROW_RUN, 0, 0, 0, 0, 0, '0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_tab[i]) begin
      case (stim_tab[i].kind)
        ROW_LOAD: begin
          send_item(1'b0, stim_tab[i].f0, stim_tab[i].f1, stim_tab[i].f2, stim_tab[i].f3,
                    1'b0, '0);
        end
        ROW_RUN: begin
          run_schedule(stim_tab[i].known, stim_tab[i].span);
        end
        ROW_CFG: begin
          write_reg(stim_tab[i].f0, stim_tab[i].f1);
        end
      endcase
    end

    write_reg(CFG_JOB_COUNT, 64);
    for (int j = 0; j < MAX_JOBS; j++) send_item(1'b0, j, 0, 0, 65535, 1'b0, '0);
    run_schedule(1'b1, BIG_SPAN);

    while (item_count < RANDOM_ITEMS) begin
      allow_gaps = item_count < RANDOM_ITEMS - 100;
      jc = $urandom_range(1, 8);
      mc = $urandom_range(1, 6);
      case ($urandom_range(0, 19))
        0: jc = 0;
        1: mc = 0;
        2: begin
          jc = $urandom_range(9, 127);
          mc = 1;
        end
        3: begin
          jc = $urandom_range(1, 2);
          mc = $urandom_range(7, 63);
        end
        default: ;
      endcase
      write_reg(CFG_JOB_COUNT, jc);
      write_reg(CFG_MACHINE_COUNT, mc);
      jc_eff = eff_jobs();
      mc_eff = eff_machs();
      repeat ($urandom_range(1, 4)) begin
        n = $urandom_range(0, jc_eff * mc_eff + 2);
        repeat (n) begin
          if ($urandom_range(0, 99) < 85 && jc_eff > 0 && mc_eff > 0) begin
            send_item(1'b0, $urandom_range(0, jc_eff - 1), $urandom_range(0, mc_eff - 1),
                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                  : $urandom_range(0, mc_eff - 1),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 15),
                      1'b0, '0);
          end else begin
            send_item(1'b0, $urandom_range(0, 63), $urandom_range(0, 31),
                      $urandom_range(0, 31), $urandom_range(0, 65535), 1'b0, '0);
          end
        end
        run_schedule(1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_spans.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/jss_pkg.sv
rtl/jss_ctrl.sv
rtl/jss_dpath.sv
rtl/job_shop_spt_dispatch_makespan.sv
rtl/jss_checker.sv
tb/sv/job_shop_spt_dispatch_makespan_tb.sv
